>>> src/tasp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tasp_pkg;

    // Gap left after every rectangle and between shelves.
    localparam int PADDING   = 2;

    localparam int COORD_W   = 12;
    localparam int SIZE_W    = 13;
    localparam int POS_W     = 13;
    localparam int CURSOR_W  = 14;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;
    // Working width inside one step; holds cursor plus shelf plus padding plus height.
    localparam int WIDE_W    = 17;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
    } t_area;

    typedef enum logic [1:0] {
        AREA_FIRST  = 2'd0,
        AREA_SECOND = 2'd1,
        AREA_DONE   = 2'd2
    } t_area_idx;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_LEFT    = 3'd0,
        REG_FIRST_TOP     = 3'd1,
        REG_FIRST_WIDTH   = 3'd2,
        REG_FIRST_HEIGHT  = 3'd3,
        REG_SECOND_LEFT   = 3'd4,
        REG_SECOND_TOP    = 3'd5,
        REG_SECOND_WIDTH  = 3'd6,
        REG_SECOND_HEIGHT = 3'd7
    } t_cfg_reg;

endpackage

`default_nettype wire

>>> src/two_area_shelf_packer_top.sv
// Two-area shelf packer.
// Request channel: i_in_valid / o_in_stall carry one rectangle (width, height)
// per beat. Result channel: o_out_valid / i_out_stall carry placed, pos_x and
// pos_y, one result beat for every request beat, in request order.
// Configuration: i_cfg_valid / o_cfg_ready with a register index and data set
// the left, top, width and height of the two free areas. Write them only while
// no request is in flight; o_cfg_ready is always high.
// A request accepted into the input register moves on to the result register,
// which offers its result beat; while that register is full and stalled, the
// request waits. Throughput is one request per cycle when the receiver does not
// stall; each request sees the state left by the one before it.
// Reset (synchronous, active low) clears the area registers, returns the packer
// to the first area with its cursor at zero and empties both pipeline stages.
// When the receiver stalls, the result register holds; the input register still
// takes one more request, and o_in_stall rises only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module two_area_shelf_packer_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [tasp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tasp_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [tasp_pkg::SIZE_W-1:0]    i_rect_width,
    input  wire logic [tasp_pkg::SIZE_W-1:0]    i_rect_height,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_placed,
    output logic [tasp_pkg::POS_W-1:0]          o_pos_x,
    output logic [tasp_pkg::POS_W-1:0]          o_pos_y
);
    import tasp_pkg::*;

    t_area w_first;
    t_area w_second;

    tasp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_first     (w_first),
        .o_second    (w_second)
    );

    tasp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_first       (w_first),
        .i_second      (w_second),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_placed      (o_placed),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y)
    );

endmodule

`default_nettype wire

>>> src/tasp_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module tasp_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [tasp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tasp_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output tasp_pkg::t_area                     o_first,
    output tasp_pkg::t_area                     o_second
);
    import tasp_pkg::*;

    t_area r_first;
    t_area r_second;

    assign o_cfg_ready = 1'b1;
    assign o_first     = r_first;
    assign o_second    = r_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= '0;
            r_second <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_FIRST_LEFT:    r_first.left    <= i_cfg_data[COORD_W-1:0];
                REG_FIRST_TOP:     r_first.top     <= i_cfg_data[COORD_W-1:0];
                REG_FIRST_WIDTH:   r_first.width   <= i_cfg_data[SIZE_W-1:0];
                REG_FIRST_HEIGHT:  r_first.height  <= i_cfg_data[SIZE_W-1:0];
                REG_SECOND_LEFT:   r_second.left   <= i_cfg_data[COORD_W-1:0];
                REG_SECOND_TOP:    r_second.top    <= i_cfg_data[COORD_W-1:0];
                REG_SECOND_WIDTH:  r_second.width  <= i_cfg_data[SIZE_W-1:0];
                REG_SECOND_HEIGHT: r_second.height <= i_cfg_data[SIZE_W-1:0];
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/tasp_core.sv
`timescale 1ns / 1ps
`default_nettype none

module tasp_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire tasp_pkg::t_area              i_first,
    input  wire tasp_pkg::t_area              i_second,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [tasp_pkg::SIZE_W-1:0]  i_rect_width,
    input  wire logic [tasp_pkg::SIZE_W-1:0]  i_rect_height,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic                              o_placed,
    output logic [tasp_pkg::POS_W-1:0]        o_pos_x,
    output logic [tasp_pkg::POS_W-1:0]        o_pos_y
);
    import tasp_pkg::*;

    localparam logic [WIDE_W-1:0] PAD = WIDE_W'(PADDING);

    // Input register
    logic              r_in_valid;
    logic [SIZE_W-1:0] r_w;
    logic [SIZE_W-1:0] r_h;

    // Result register
    logic              r_out_valid;
    logic              r_placed;
    logic [POS_W-1:0]  r_pos_x;
    logic [POS_W-1:0]  r_pos_y;

    // Packer state
    t_area_idx           r_area;
    logic [CURSOR_W-1:0] r_cx;
    logic [CURSOR_W-1:0] r_cy;
    logic [SIZE_W-1:0]   r_sh;

    t_area_idx           n_area;
    logic [CURSOR_W-1:0] n_cx;
    logic [CURSOR_W-1:0] n_cy;
    logic [SIZE_W-1:0]   n_sh;
    logic                n_placed;
    logic [POS_W-1:0]    n_pos_x;
    logic [POS_W-1:0]    n_pos_y;

    logic              w_adv;
    logic              w_fire;
    t_area             w_cur;
    logic              w_active;
    logic              w_wrap;
    logic [WIDE_W-1:0] w_x;
    logic [WIDE_W-1:0] w_y;
    logic [SIZE_W-1:0] w_s;
    logic              w_fit_cur;
    logic              w_fit_nxt;
    logic [WIDE_W-1:0] w_w;
    logic [WIDE_W-1:0] w_h;
    logic [WIDE_W-1:0] w_px;
    logic [WIDE_W-1:0] w_py;
    logic [WIDE_W-1:0] w_ncx;

    assign w_adv       = !r_out_valid || !i_out_stall;
    assign w_fire      = r_in_valid && w_adv;
    assign o_in_stall  = r_in_valid && !w_adv;
    assign o_out_valid = r_out_valid;
    assign o_placed    = r_placed;
    assign o_pos_x     = r_pos_x;
    assign o_pos_y     = r_pos_y;

    assign w_w = WIDE_W'(r_w);
    assign w_h = WIDE_W'(r_h);

    // Trial in the current area, with the new-shelf step folded in, and in a fresh second area.
    always_comb begin
        w_cur    = (r_area == AREA_SECOND) ? i_second : i_first;
        w_active = (r_area == AREA_FIRST) || (r_area == AREA_SECOND);
        w_wrap   = (WIDE_W'(r_cx) + w_w) > WIDE_W'(w_cur.width);
        w_x      = w_wrap ? '0 : WIDE_W'(r_cx);
        w_y      = w_wrap ? (WIDE_W'(r_cy) + WIDE_W'(r_sh) + PAD) : WIDE_W'(r_cy);
        w_s      = w_wrap ? '0 : r_sh;
        w_fit_cur = w_active && (w_w <= WIDE_W'(w_cur.width))
                    && ((w_y + w_h) <= WIDE_W'(w_cur.height));
        // A fresh second area fits exactly when the rectangle fits its size.
        w_fit_nxt = (r_area == AREA_FIRST) && (w_w <= WIDE_W'(i_second.width))
                    && (w_h <= WIDE_W'(i_second.height));
        w_px  = WIDE_W'(w_cur.left) + w_x;
        w_py  = WIDE_W'(w_cur.top) + w_y;
        w_ncx = w_x + w_w + PAD;
    end

    always_comb begin
        n_area   = AREA_DONE;
        n_cx     = '0;
        n_cy     = '0;
        n_sh     = '0;
        n_placed = 1'b0;
        n_pos_x  = '0;
        n_pos_y  = '0;
        priority if (w_fit_cur) begin
            n_area   = r_area;
            n_placed = 1'b1;
            n_pos_x  = w_px[POS_W-1:0];
            n_pos_y  = w_py[POS_W-1:0];
            n_cx     = w_ncx[CURSOR_W-1:0];
            n_cy     = w_y[CURSOR_W-1:0];
            n_sh     = (w_s > r_h) ? w_s : r_h;
        end else if (w_fit_nxt) begin
            n_area   = AREA_SECOND;
            n_placed = 1'b1;
            n_pos_x  = POS_W'(i_second.left);
            n_pos_y  = POS_W'(i_second.top);
            n_cx     = CURSOR_W'(w_w + PAD);
            n_cy     = '0;
            n_sh     = r_h;
        end else begin
            n_area   = AREA_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_w <= i_rect_width;
            r_h <= i_rect_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_placed <= n_placed;
            r_pos_x  <= n_pos_x;
            r_pos_y  <= n_pos_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area <= AREA_FIRST;
            r_cx   <= '0;
            r_cy   <= '0;
            r_sh   <= '0;
        end else if (w_fire) begin
            r_area <= n_area;
            r_cx   <= n_cx;
            r_cy   <= n_cy;
            r_sh   <= n_sh;
        end
    end

    // Once both areas are used up the cursor stays cleared.
    a_done_cursor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_area == AREA_DONE) |-> (r_cx == '0 && r_cy == '0 && r_sh == '0))
        else $error("cursor not cleared after both areas were used up");

    // The packer never returns to the first area without a reset.
    a_area_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_area != AREA_FIRST) |=> (r_area != AREA_FIRST))
        else $error("area index moved backward");

    // A failed placement carries a zero position.
    a_fail_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_placed) |-> (r_pos_x == '0 && r_pos_y == '0))
        else $error("failed placement with nonzero position");

    // State only advances when an item moves into the result register.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> ($stable(r_area) && $stable(r_cx) && $stable(r_cy) && $stable(r_sh)))
        else $error("packer state changed without a request");

    // Backpressure only when a request is held and the result cannot drain.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import tasp_pkg::*;

    typedef struct packed {
        logic             placed;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
    } t_placement;

    // Tracks the packer state and queues the placement each request should produce.
    class shelf_placement_board;
        logic [COORD_W-1:0]  left [2];
        logic [COORD_W-1:0]  top [2];
        logic [SIZE_W-1:0]   width [2];
        logic [SIZE_W-1:0]   height [2];
        t_area_idx           area_idx;
        logic [CURSOR_W-1:0] cursor_x;
        logic [CURSOR_W-1:0] cursor_y;
        logic [SIZE_W-1:0]   shelf_h;
        t_placement          placements_due [$];
        int                  errors;

        function new();
            left = '{'0, '0};
            top = '{'0, '0};
            width = '{'0, '0};
            height = '{'0, '0};
            area_idx = AREA_FIRST;
            cursor_x = '0;
            cursor_y = '0;
            shelf_h = '0;
            errors = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_FIRST_LEFT:    left[0] = data[COORD_W-1:0];
                REG_FIRST_TOP:     top[0] = data[COORD_W-1:0];
                REG_FIRST_WIDTH:   width[0] = data;
                REG_FIRST_HEIGHT:  height[0] = data;
                REG_SECOND_LEFT:   left[1] = data[COORD_W-1:0];
                REG_SECOND_TOP:    top[1] = data[COORD_W-1:0];
                REG_SECOND_WIDTH:  width[1] = data;
                REG_SECOND_HEIGHT: height[1] = data;
                default: ;
            endcase
        endfunction

        function int unsigned area_width();
            if (area_idx == AREA_DONE) begin
                return 8191;
            end
            return width[(area_idx == AREA_FIRST) ? 1'b0 : 1'b1];
        endfunction

        function void place_request(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
            bit          a;
            int unsigned x;
            int unsigned y;
            int unsigned s;
            t_placement  res;
            res = '0;
            while (area_idx != AREA_DONE) begin
                a = (area_idx == AREA_FIRST) ? 1'b0 : 1'b1;
                x = cursor_x;
                y = cursor_y;
                s = shelf_h;
                // Not enough room left on this shelf: open a new one below it.
                if (x + w > width[a]) begin
                    x = 0;
                    y = y + s + PADDING;
                    s = 0;
                end
                if (w <= width[a] && y + h <= height[a]) begin
                    res.placed = 1'b1;
                    res.pos_x = POS_W'(left[a] + x);
                    res.pos_y = POS_W'(top[a] + y);
                    cursor_x = CURSOR_W'(x + w + PADDING);
                    cursor_y = CURSOR_W'(y);
                    shelf_h = SIZE_W'((s > h) ? s : h);
                    break;
                end
                area_idx = (area_idx == AREA_FIRST) ? AREA_SECOND : AREA_DONE;
                cursor_x = '0;
                cursor_y = '0;
                shelf_h = '0;
            end
            placements_due.insert(placements_due.size(), res);
        endfunction

        function void check_placement(logic placed, logic [POS_W-1:0] px,
                                      logic [POS_W-1:0] py);
            t_placement exp;
            if (placements_due.size() == 0) begin
                $error("result beat with nothing pending: placed %0d x %0d y %0d",
                       placed, px, py);
                errors++;
                return;
            end
            exp = placements_due.pop_front();
            if (placed !== exp.placed) begin
                $error("placed: expected %0d, actual %0d", exp.placed, placed);
                errors++;
            end
            if (px !== exp.pos_x) begin
                $error("pos_x: expected %0d, actual %0d", exp.pos_x, px);
                errors++;
            end
            if (py !== exp.pos_y) begin
                $error("pos_y: expected %0d, actual %0d", exp.pos_y, py);
                errors++;
            end
        endfunction
    endclass

    localparam int DIRECTED_N = 12;
    localparam logic [SIZE_W-1:0] DIR_W [DIRECTED_N] =
        '{8191, 0, 100, 200, 7000, 1000, 4096, 4095, 0, 8191, 17, 1};
    localparam logic [SIZE_W-1:0] DIR_H [DIRECTED_N] =
        '{1, 0, 50, 10, 30, 5, 16, 8, 40, 0, 3, 1};
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 140;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [SIZE_W-1:0]    rect_width = '0;
    logic [SIZE_W-1:0]    rect_height = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 placed;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;

    shelf_placement_board board;
    int                   results_seen = 0;
    int                   burst_left = 5;

    two_area_shelf_packer_top i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_rect_width  (rect_width),
        .i_rect_height (rect_height),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_placed      (placed),
        .o_pos_x       (pos_x),
        .o_pos_y       (pos_y)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            board.check_placement(placed, pos_x, pos_y);
            results_seen++;
        end
    end

    // Receiver: the stall pattern switches among four random modes, with one long hold-off
    // so the request side backs up.
    initial begin
        int mode;
        int span;
        bit long_hold_done;
        mode = 0;
        span = 0;
        long_hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (!long_hold_done && results_seen >= 300) begin
                long_hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (100) @(posedge clk);
            end
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 64);
            end
            span--;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 9) < 3);
                2: out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= (span % 3 == 0);
            endcase
        end
    end

    task automatic send_rect(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        int gap;
        in_valid <= 1'b1;
        rect_width <= w;
        rect_height <= h;
        do @(posedge clk); while (in_stall);
        board.place_request(w, h);
        burst_left--;
        if (burst_left <= 0) begin
            in_valid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last beat.
    task automatic program_reg(input t_cfg_reg idx, input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, data);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.placements_due.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    function automatic int unsigned pick_width();
        case ($urandom_range(0, 3))
            0: return 8191;
            1: return 4096;
            default: return $urandom_range(256, 2048);
        endcase
    endfunction

    // Phases 0-3 pack into the first area, 4-6 into the second, and the last phase
    // zeroes both heights so that only a rectangle of zero height at the top can fit.
    task automatic configure_phase(input int p);
        int unsigned lo;
        int unsigned tgt;
        logic [CFG_DAT_W-1:0] wd;
        logic [CFG_DAT_W-1:0] ht;
        tgt = (p < 4) ? 0 : 1;
        for (int a = 0; a < 2; a++) begin
            if (p == PHASES - 1) begin
                wd = CFG_DAT_W'($urandom_range(0, 8191));
                ht = '0;
            end else if (a == tgt) begin
                wd = CFG_DAT_W'(pick_width());
                lo = ((board.area_idx == AREA_FIRST) == (a == 0)) ? board.cursor_y : 0;
                lo = (lo + 1200 > 8191) ? 8191 : lo + 1200;
                ht = CFG_DAT_W'($urandom_range(lo, 8191));
            end else if (a == 0) begin
                wd = CFG_DAT_W'($urandom_range(0, 8191));
                ht = '0;
            end else begin
                wd = CFG_DAT_W'(pick_width());
                ht = CFG_DAT_W'($urandom_range(1200, 8191));
            end
            program_reg((a == 0) ? REG_FIRST_LEFT : REG_SECOND_LEFT,
                        CFG_DAT_W'($urandom_range(0, 8191)));
            program_reg((a == 0) ? REG_FIRST_TOP : REG_SECOND_TOP,
                        CFG_DAT_W'($urandom_range(0, 8191)));
            program_reg((a == 0) ? REG_FIRST_WIDTH : REG_SECOND_WIDTH, wd);
            program_reg((a == 0) ? REG_FIRST_HEIGHT : REG_SECOND_HEIGHT, ht);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
        int unsigned cw;
        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With all registers still zero, only an empty rectangle at the shelf top fits.
        send_rect(0, 0);
        drain();

        // Left edge data has bit 12 set and the second top is 4096; both drop to 12 bits.
        program_reg(REG_FIRST_LEFT, 8191);
        program_reg(REG_FIRST_TOP, 4095);
        program_reg(REG_FIRST_WIDTH, 8191);
        program_reg(REG_FIRST_HEIGHT, 8191);
        program_reg(REG_SECOND_LEFT, 0);
        program_reg(REG_SECOND_TOP, 4096);
        program_reg(REG_SECOND_WIDTH, 4096);
        program_reg(REG_SECOND_HEIGHT, 4096);
        cfg_valid <= 1'b0;
        @(posedge clk);
        for (int i = 0; i < DIRECTED_N; i++) begin
            send_rect(DIR_W[i], DIR_H[i]);
        end
        drain();

        for (int p = 0; p < PHASES; p++) begin
            configure_phase(p);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == PHASES - 1) begin
                    w = SIZE_W'($urandom_range(0, 8191));
                    h = SIZE_W'($urandom_range(0, 8191));
                end else begin
                    cw = board.area_width();
                    w = ($urandom_range(0, 99) < 90)
                        ? SIZE_W'($urandom_range(0, (cw < 40) ? cw : 40))
                        : SIZE_W'($urandom_range(0, cw));
                    h = ($urandom_range(0, 99) < 95) ? SIZE_W'($urandom_range(0, 40))
                                                     : SIZE_W'($urandom_range(0, 256));
                end
                send_rect(w, h);
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (board.errors == 0 && board.placements_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> files.f
src/tasp_pkg.sv
src/tasp_cfg_regs.sv
src/tasp_core.sv
src/two_area_shelf_packer_top.sv
tb/tb.sv
